[src/plsu_pkg.sv]
// ----------------------------------------------------------------------------
// plsu_pkg: shared types and constants of the positional list store
// Word layouts of both channels, request kinds, status codes and the
// per-cell command bundle broadcast along the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package plsu_pkg;

	localparam int DEF_CAPACITY   = 64;
	localparam int DEF_ELEM_WIDTH = 32;
	localparam int KIND_W         = 3;
	localparam int POS_W          = 7;
	localparam int VAL_W          = 32;
	localparam int STATUS_W       = 2;
	localparam int GROUP_SIZE     = 8;
	localparam int GROUP_OFF_W    = 3;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 3'd0,
		KIND_REMOVE = 3'd1,
		KIND_MODIFY = 3'd2,
		KIND_READ   = 3'd3,
		KIND_FIND   = 3'd4
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0]  position;
		logic [VAL_W-1:0]  value;
	} in_word_t;

	typedef struct packed {
		logic [VAL_W-1:0]    data;
		logic [POS_W-1:0]    found_position;
		logic [POS_W-1:0]    length;
		logic [STATUS_W-1:0] status;
	} out_word_t;

	// One-hot operation bundle seen by every cell
	typedef struct packed {
		logic ins;
		logic rem;
		logic mdf;
		logic rd;
		logic fnd;
	} cell_cmd_t;

endpackage

`default_nettype wire

[src/plsu_cell.sv]
// ----------------------------------------------------------------------------
// plsu_cell: one list slot
// Holds one entry, loads from its left or right neighbor on a shift, takes
// the request word on a direct write, and reports match and read data.
// ----------------------------------------------------------------------------
`default_nettype none

module plsu_cell #(
	parameter int ELEM_WIDTH = 32,
	parameter int CAPACITY   = 64,
	parameter int IDX        = 0
) (
	input  wire logic                            clk,
	input  wire plsu_pkg::cell_cmd_t             cmd,
	input  wire logic [$clog2(CAPACITY)-1:0]     sel,
	input  wire logic [$clog2(CAPACITY+1)-1:0]   cnt,
	input  wire logic [ELEM_WIDTH-1:0]           value,
	input  wire logic [ELEM_WIDTH-1:0]           left,
	input  wire logic [ELEM_WIDTH-1:0]           right,
	output logic      [ELEM_WIDTH-1:0]           entry,
	output logic                                 hit,
	output logic      [ELEM_WIDTH-1:0]           rdat
);
	import plsu_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [IW-1:0] MY_I  = IW'(IDX);
	localparam logic [CW-1:0] MY_C  = CW'(IDX);
	localparam logic [CW:0]   MY_P1 = (CW + 1)'(IDX + 1);

	logic [ELEM_WIDTH-1:0] entry_q;
	logic [CW-1:0]         sel_c;
	logic                  at_sel;

	assign sel_c  = CW'(sel);
	assign at_sel = (sel == MY_I);

	// Advance the slot: write, shift up, shift down or hold
	always_ff @(posedge clk) begin
		if ((cmd.ins || cmd.mdf) && at_sel) begin
			entry_q <= value;
		end else if (cmd.ins && (MY_C > sel_c) && (MY_C <= cnt)) begin
			entry_q <= left;
		end else if (cmd.rem && (MY_C >= sel_c) && (MY_P1 < {1'b0, cnt})) begin
			entry_q <= right;
		end
	end

	assign entry = entry_q;

	// Match and read taps for the reduction stage
	assign hit  = cmd.fnd && (MY_C < cnt) && (entry_q == value);
	assign rdat = (cmd.rd && at_sel) ? entry_q : '0;

endmodule

`default_nettype wire

[src/plsu_reduce.sv]
// ----------------------------------------------------------------------------
// plsu_reduce: registered match and read reduction
// Collapses the per-cell match flags and read taps in groups of eight into
// a register, then picks the first hit group for the final position.
// ----------------------------------------------------------------------------
`default_nettype none

module plsu_reduce #(
	parameter int ELEM_WIDTH = 32,
	parameter int CAPACITY   = 64
) (
	input  wire logic                                    clk,
	input  wire logic                                    en,
	input  wire logic [CAPACITY-1:0]                     hits,
	input  wire logic [CAPACITY-1:0][ELEM_WIDTH-1:0]     rdat,
	output logic      [$clog2(CAPACITY+1)-1:0]           found,
	output logic      [ELEM_WIDTH-1:0]                   data
);
	import plsu_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int NG = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

	logic [NG-1:0]                    ghit_c;
	logic [NG-1:0][GROUP_OFF_W-1:0]   goff_c;
	logic [NG-1:0][ELEM_WIDTH-1:0]    gdat_c;
	logic [NG-1:0]                    ghit_s1;
	logic [NG-1:0][GROUP_OFF_W-1:0]   goff_s1;
	logic [NG-1:0][ELEM_WIDTH-1:0]    gdat_s1;

	// Reduce each group of eight cells
	always_comb begin
		ghit_c = '0;
		goff_c = '0;
		gdat_c = '0;
		for (int g = 0; g < NG; g++) begin
			for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
				if (g * GROUP_SIZE + j < CAPACITY) begin
					if (hits[g * GROUP_SIZE + j]) begin
						ghit_c[g] = 1'b1;
						goff_c[g] = GROUP_OFF_W'(j);
					end
					gdat_c[g] = gdat_c[g] | rdat[g * GROUP_SIZE + j];
				end
			end
		end
	end

	// Hold group results for the second stage
	always_ff @(posedge clk) begin
		if (en) begin
			ghit_s1 <= ghit_c;
			goff_s1 <= goff_c;
			gdat_s1 <= gdat_c;
		end
	end

	// Pick the first hit group and merge read data
	always_comb begin
		found = '0;
		data  = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (ghit_s1[g]) begin
				found = CW'(g * GROUP_SIZE) + CW'(goff_s1[g]) + CW'(1);
			end
		end
		for (int g = 0; g < NG; g++) begin
			data = data | gdat_s1[g];
		end
	end

endmodule

`default_nettype wire

[src/positional_list_store_unit.sv]
// ----------------------------------------------------------------------------
// positional_list_store_unit: bounded ordered list in a row of cells
// Keeps up to CAPACITY words by 1-based position; insert, remove, modify,
// read and find requests, each answered by one result word.
// ----------------------------------------------------------------------------
// Usage:
//  - in_word (kind, position, value) enters on in_valid/in_ready; out_word
//    (data, found_position, length, status) leaves on out_valid/out_ready.
//  - The cell row applies an insert or remove shift, or a direct write, at
//    the edge that accepts the request; every cell compares in that cycle.
//  - After acceptance the result passes the group reduction register and
//    then the output register.
//  - One request per cycle is sustained while the receiver takes words.
//  - When out_ready is low, one word waits in the output register and one
//    in the reduction stage; in_ready then drops until the output frees.
//  - Reset empties the list (length zero) and clears all handshake state;
//    entry contents are not cleared and are never shown before written.
//  - Invalid requests report status 1 (range) or 2 (full) and change nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_store_unit #(
	parameter int CAPACITY   = plsu_pkg::DEF_CAPACITY,
	parameter int ELEM_WIDTH = plsu_pkg::DEF_ELEM_WIDTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire plsu_pkg::in_word_t  in_word,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output plsu_pkg::out_word_t      out_word
);
	import plsu_pkg::*;

	localparam int IW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

	logic [CW-1:0]                  count_q;
	logic [CW-1:0]                  count_nx;
	logic                           s1_valid_q;
	logic [POS_W-1:0]               len_s1;
	status_t                        status_s1;
	logic                           out_valid_q;
	out_word_t                      out_word_q;

	logic                           acc;
	logic                           advance;
	cell_cmd_t                      cmd_c;
	cell_cmd_t                      cmd;
	status_t                        status_c;
	logic [CMPW-1:0]                pos_c;
	logic [CMPW-1:0]                cnt_c;
	logic                           pos_ok;
	logic                           ins_ok;
	logic                           full;
	logic [POS_W-1:0]               pos_m1;
	logic [IW-1:0]                  sel;
	logic [63:0]                    val_wide;
	logic [ELEM_WIDTH-1:0]          val_e;

	logic [CAPACITY-1:0][ELEM_WIDTH-1:0] entries;
	logic [CAPACITY-1:0][ELEM_WIDTH-1:0] rdat;
	logic [CAPACITY-1:0]                 hits;
	logic [CW-1:0]                       found;
	logic [ELEM_WIDTH-1:0]               rd_data;
	logic [63:0]                         data_wide;

	// Handshake: reduction stage drains into the output register
	assign advance   = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready  = !s1_valid_q || advance;
	assign acc       = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// Range checks against the current length
	assign pos_c    = CMPW'(in_word.position);
	assign cnt_c    = CMPW'(count_q);
	assign full     = (count_q == CW'(CAPACITY));
	assign pos_ok   = (pos_c != '0) && (pos_c <= cnt_c);
	assign ins_ok   = (pos_c != '0) && (pos_c <= cnt_c + CMPW'(1));
	assign pos_m1   = in_word.position - POS_W'(1);
	assign sel      = IW'(pos_m1);
	assign val_wide = 64'(in_word.value);
	assign val_e    = val_wide[ELEM_WIDTH-1:0];

	// Decode the request into a cell command, status and next length
	always_comb begin
		cmd_c    = '0;
		status_c = ST_OK;
		count_nx = count_q;
		unique case (in_word.kind)
			KIND_INSERT: begin
				if (full) begin
					status_c = ST_FULL;
				end else if (!ins_ok) begin
					status_c = ST_RANGE;
				end else begin
					cmd_c.ins = 1'b1;
					count_nx  = count_q + CW'(1);
				end
			end
			KIND_REMOVE: begin
				if (!pos_ok) begin
					status_c = ST_RANGE;
				end else begin
					cmd_c.rem = 1'b1;
					count_nx  = count_q - CW'(1);
				end
			end
			KIND_MODIFY: begin
				if (!pos_ok) status_c = ST_RANGE;
				else         cmd_c.mdf = 1'b1;
			end
			KIND_READ: begin
				if (!pos_ok) status_c = ST_RANGE;
				else         cmd_c.rd = 1'b1;
			end
			KIND_FIND: begin
				cmd_c.fnd = 1'b1;
			end
			default: begin
				status_c = ST_RANGE;
			end
		endcase
	end

	assign cmd = acc ? cmd_c : '0;

	// Row of cells, each handing its entry to both neighbors
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ELEM_WIDTH-1:0] left_n;
		logic [ELEM_WIDTH-1:0] right_n;
		if (i == 0) begin : g_first
			assign left_n = val_e;
		end else begin : g_mid_l
			assign left_n = entries[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_n = entries[i];
		end else begin : g_mid_r
			assign right_n = entries[i+1];
		end
		plsu_cell #(
			.ELEM_WIDTH (ELEM_WIDTH),
			.CAPACITY   (CAPACITY),
			.IDX        (i)
		) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.sel   (sel),
			.cnt   (count_q),
			.value (val_e),
			.left  (left_n),
			.right (right_n),
			.entry (entries[i]),
			.hit   (hits[i]),
			.rdat  (rdat[i])
		);
	end

	plsu_reduce #(
		.ELEM_WIDTH (ELEM_WIDTH),
		.CAPACITY   (CAPACITY)
	) u_reduce (
		.clk   (clk),
		.en    (acc),
		.hits  (hits),
		.rdat  (rdat),
		.found (found),
		.data  (rd_data)
	);

	assign data_wide = 64'(rd_data);

	// Length register and reduction-stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (acc) count_q <= count_nx;
			if (acc)          s1_valid_q <= 1'b1;
			else if (advance) s1_valid_q <= 1'b0;
		end
	end

	// Stage payload travels beside the group registers
	always_ff @(posedge clk) begin
		if (acc) begin
			len_s1    <= POS_W'(count_nx);
			status_s1 <= status_c;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result word
	always_ff @(posedge clk) begin
		if (advance) begin
			out_word_q.data           <= data_wide[VAL_W-1:0];
			out_word_q.found_position <= POS_W'(found);
			out_word_q.length         <= len_s1;
			out_word_q.status         <= status_s1;
		end
	end

endmodule

`default_nettype wire

[src/plsu_checker.sv]
// ----------------------------------------------------------------------------
// plsu_checker: port-level checks of the positional list store
// Watches both channels and the fields of each result word.
// ----------------------------------------------------------------------------
`default_nettype none

module plsu_checker #(
	parameter int CAPACITY = plsu_pkg::DEF_CAPACITY
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_ready,
	input  wire logic                 out_valid,
	input  wire logic                 out_ready,
	input  wire plsu_pkg::out_word_t  out_word
);
	import plsu_pkg::*;

	// Stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	// Input stalls only behind a stalled output
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled while output free");

	// Full report comes with a full length and no payload
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.status == ST_FULL |->
			out_word.length == POS_W'(CAPACITY) && out_word.data == '0 &&
			out_word.found_position == '0)
		else $error("full status with inconsistent fields");

	// A found position lies inside the list and reports ok
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.found_position != '0 |->
			out_word.found_position <= out_word.length && out_word.status == ST_OK)
		else $error("found position outside list");

endmodule

bind positional_list_store_unit plsu_checker #(.CAPACITY(CAPACITY)) u_plsu_checker (.*);

`default_nettype wire
